FILE: src/sbnm_pkg.sv
// Shared constants, codes and control/status types for the serial buffering engine.
`default_nettype none
package sbnm_pkg;

    localparam int RING_DEPTH  = 2048;
    localparam int MAX_READERS = 16;
    localparam int PTR_W       = $clog2(RING_DEPTH);
    localparam int LVL_W       = $clog2(RING_DEPTH + 1);
    localparam int WAIT_W      = $clog2(MAX_READERS + 1);

    localparam logic [PTR_W-1:0]  LAST_PTR   = PTR_W'(RING_DEPTH - 1);
    localparam logic [LVL_W-1:0]  FULL_LVL   = LVL_W'(RING_DEPTH);
    localparam logic [WAIT_W-1:0] WAIT_LIMIT = WAIT_W'(MAX_READERS);

    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_LF = 8'h0a;

    // item commands
    localparam logic [2:0] CMD_RX_BYTE   = 3'd0;
    localparam logic [2:0] CMD_READ      = 3'd1;
    localparam logic [2:0] CMD_WRITE     = 3'd2;
    localparam logic [2:0] CMD_WRITE_RAW = 3'd3;
    localparam logic [2:0] CMD_TX_READY  = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_TX_BYTE  = 2'd0;
    localparam logic [1:0] KIND_RD_BYTE  = 2'd1;
    localparam logic [1:0] KIND_RD_EMPTY = 2'd2;
    localparam logic [1:0] KIND_TX_IDLE  = 2'd3;

    // result byte sources
    localparam logic [2:0] SEL_ZERO  = 3'd0;
    localparam logic [2:0] SEL_RXMAP = 3'd1;
    localparam logic [2:0] SEL_CR    = 3'd2;
    localparam logic [2:0] SEL_DATA  = 3'd3;
    localparam logic [2:0] SEL_RXMEM = 3'd4;
    localparam logic [2:0] SEL_TXMEM = 3'd5;

    // config register indexes
    localparam logic CFG_RX_CR_TO_LF   = 1'b0;
    localparam logic CFG_TX_LF_TO_CRLF = 1'b1;

    typedef struct packed {
        logic [2:0] cmd;
        logic       sending;
        logic       rx_empty;
        logic       rx_full;
        logic       tx_empty;
        logic       tx_full;
        logic       wait_zero;
        logic       wait_max;
        logic       lf_expand;
    } sbnm_status_t;

    typedef struct packed {
        logic       capture;
        logic       rx_push;
        logic       rx_pop;
        logic       wait_inc;
        logic       wait_dec;
        logic       tx_push;
        logic       tx_push_cr;
        logic       tx_pop;
        logic       tx_stop;
        logic       send_start;
        logic       res_set;
        logic [1:0] res_kind;
        logic [2:0] res_sel;
        logic       out_load;
    } sbnm_cmd_t;

endpackage
`default_nettype wire

FILE: src/serial_buffered_io_with_newline_map.sv
// Top level of the serial buffering engine: controller, datapath and checks.
`default_nettype none
// Serial buffering engine with a 2048-byte receive ring and a 2048-byte transmit
// ring, each a single-port-write, registered-read memory. One item is handled at
// a time: an item with no result (byte stored or queued, ignored command) is
// captured and executed; one with a result then waits in the emit state until
// the result register is loaded; a write queuing both CR and LF while sending
// adds state S_WR2, as the transmit ring takes one write per cycle. The next
// item is taken while an earlier result still waits in the output register; a
// second result waits for it to drain. Configuration writes are always accepted.
module serial_buffered_io_with_newline_map (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [2:0]             cmd,
    input  wire logic [7:0]             data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [1:0]                  kind,
    output logic [7:0]                  byte_out,
    output logic [sbnm_pkg::LVL_W-1:0]  rx_level,
    output logic [sbnm_pkg::LVL_W-1:0]  tx_level,
    output logic                        busy_sending,
    output logic [sbnm_pkg::WAIT_W-1:0] readers_blocked,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic                   cfg_index,
    input  wire logic                   cfg_data
);
    import sbnm_pkg::*;

    sbnm_cmd_t    cm;
    sbnm_status_t st;

    sbnm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .st        (st),
        .cm        (cm)
    );

    sbnm_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .data            (data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cm              (cm),
        .st              (st),
        .kind            (kind),
        .byte_out        (byte_out),
        .rx_level        (rx_level),
        .tx_level        (tx_level),
        .busy_sending    (busy_sending),
        .readers_blocked (readers_blocked)
    );

    a_rx_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cm.rx_push |-> !st.rx_full && !cm.rx_pop)
        else $error("receive push while ring full or popping");

    a_tx_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cm.tx_pop |-> st.sending && !st.tx_empty)
        else $error("transmit pop while idle or empty");

    a_result_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cm.res_set |=> !in_ready)
        else $error("item taken while a result is pending");

    a_idle_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cm.out_load |=> (kind != KIND_TX_IDLE) || !busy_sending)
        else $error("transmit idle reported while sending");

endmodule
`default_nettype wire

FILE: src/sbnm_ctrl.sv
// Controller state machine: sequences one item through execute, second write and result.
`default_nettype none
module sbnm_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    input  wire sbnm_pkg::sbnm_status_t st,
    output sbnm_pkg::sbnm_cmd_t        cm
);
    import sbnm_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WR2  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        cm         = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cm.capture = in_valid;
                if (in_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                case (st.cmd)
                    CMD_RX_BYTE:
                    begin
                        if (!st.wait_zero)
                        begin
                            cm.wait_dec = 1'b1;
                            cm.res_set  = 1'b1;
                            cm.res_kind = KIND_RD_BYTE;
                            cm.res_sel  = SEL_RXMAP;
                            state_next  = S_EMIT;
                        end
                        else
                            cm.rx_push = !st.rx_full;
                    end
                    CMD_READ:
                    begin
                        cm.res_set = 1'b1;
                        state_next = S_EMIT;
                        if (!st.rx_empty)
                        begin
                            cm.rx_pop   = 1'b1;
                            cm.res_kind = KIND_RD_BYTE;
                            cm.res_sel  = SEL_RXMEM;
                        end
                        else
                        begin
                            cm.wait_inc = !st.wait_max;
                            cm.res_kind = KIND_RD_EMPTY;
                            cm.res_sel  = SEL_ZERO;
                        end
                    end
                    CMD_WRITE, CMD_WRITE_RAW:
                    begin
                        if (st.sending)
                        begin
                            // raw writes skip the LF expansion while sending
                            cm.tx_push = !st.tx_full;
                            if (st.cmd == CMD_WRITE && st.lf_expand)
                            begin
                                cm.tx_push_cr = 1'b1;
                                state_next    = S_WR2;
                            end
                        end
                        else
                        begin
                            cm.send_start = 1'b1;
                            cm.res_set    = 1'b1;
                            cm.res_kind   = KIND_TX_BYTE;
                            state_next    = S_EMIT;
                            if (st.lf_expand)
                            begin
                                cm.res_sel = SEL_CR;
                                cm.tx_push = !st.tx_full;
                            end
                            else
                                cm.res_sel = SEL_DATA;
                        end
                    end
                    CMD_TX_READY:
                    begin
                        cm.res_set = 1'b1;
                        state_next = S_EMIT;
                        if (st.sending && !st.tx_empty)
                        begin
                            cm.tx_pop   = 1'b1;
                            cm.res_kind = KIND_TX_BYTE;
                            cm.res_sel  = SEL_TXMEM;
                        end
                        else
                        begin
                            cm.tx_stop  = 1'b1;
                            cm.res_kind = KIND_TX_IDLE;
                            cm.res_sel  = SEL_ZERO;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_WR2:
            begin
                cm.tx_push = !st.tx_full;
                state_next = S_IDLE;
            end
            S_EMIT:
            begin
                cm.out_load = !out_valid_reg || out_ready;
                if (cm.out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cm.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

FILE: src/sbnm_dp.sv
// Datapath: item registers, both ring memories, counters, config registers and result register.
`default_nettype none
module sbnm_dp (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [2:0]            cmd,
    input  wire logic [7:0]            data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic                  cfg_index,
    input  wire logic                  cfg_data,
    input  wire sbnm_pkg::sbnm_cmd_t   cm,
    output sbnm_pkg::sbnm_status_t     st,
    output logic [1:0]                 kind,
    output logic [7:0]                 byte_out,
    output logic [sbnm_pkg::LVL_W-1:0] rx_level,
    output logic [sbnm_pkg::LVL_W-1:0] tx_level,
    output logic                       busy_sending,
    output logic [sbnm_pkg::WAIT_W-1:0] readers_blocked
);
    import sbnm_pkg::*;

    logic [7:0] rx_mem [RING_DEPTH];
    logic [7:0] tx_mem [RING_DEPTH];

    logic              rx_cr_to_lf_reg, tx_lf_to_crlf_reg;
    logic [2:0]        cmd_reg;
    logic [7:0]        data_reg;
    logic [PTR_W-1:0]  rx_head_reg, rx_head_next;
    logic [LVL_W-1:0]  rx_count_reg, rx_count_next;
    logic [PTR_W-1:0]  tx_head_reg, tx_head_next;
    logic [LVL_W-1:0]  tx_count_reg, tx_count_next;
    logic              sending_reg, sending_next;
    logic [WAIT_W-1:0] wait_reg, wait_next;
    logic [1:0]        res_kind_reg;
    logic [2:0]        res_sel_reg;
    logic [7:0]        rx_q_reg, tx_q_reg;
    logic [1:0]        kind_reg;
    logic [7:0]        byte_reg;
    logic [LVL_W-1:0]  rx_level_reg, tx_level_reg;
    logic              busy_reg;
    logic [WAIT_W-1:0] readers_reg;

    logic [7:0]       rx_byte, tx_byte, res_byte;
    logic [LVL_W:0]   rx_sum, tx_sum;
    logic [PTR_W-1:0] rx_wr_addr, tx_wr_addr;

    assign cfg_ready = 1'b1;

    assign rx_byte = (data_reg == CH_CR && rx_cr_to_lf_reg) ? CH_LF : data_reg;
    assign tx_byte = cm.tx_push_cr ? CH_CR : data_reg;

    // tail address = head + count, wrapped once
    assign rx_sum = (LVL_W+1)'(rx_head_reg) + (LVL_W+1)'(rx_count_reg);
    assign tx_sum = (LVL_W+1)'(tx_head_reg) + (LVL_W+1)'(tx_count_reg);
    assign rx_wr_addr = (rx_sum >= (LVL_W+1)'(RING_DEPTH))
                      ? PTR_W'(rx_sum - (LVL_W+1)'(RING_DEPTH)) : PTR_W'(rx_sum);
    assign tx_wr_addr = (tx_sum >= (LVL_W+1)'(RING_DEPTH))
                      ? PTR_W'(tx_sum - (LVL_W+1)'(RING_DEPTH)) : PTR_W'(tx_sum);

    always_comb
    begin
        st.cmd       = cmd_reg;
        st.sending   = sending_reg;
        st.rx_empty  = (rx_count_reg == '0);
        st.rx_full   = (rx_count_reg == FULL_LVL);
        st.tx_empty  = (tx_count_reg == '0);
        st.tx_full   = (tx_count_reg == FULL_LVL);
        st.wait_zero = (wait_reg == '0);
        st.wait_max  = (wait_reg == WAIT_LIMIT);
        st.lf_expand = (data_reg == CH_LF) && tx_lf_to_crlf_reg;
    end

    always_comb
    begin
        rx_head_next  = rx_head_reg;
        rx_count_next = rx_count_reg;
        if (cm.rx_push)
            rx_count_next = rx_count_reg + 1'b1;
        else if (cm.rx_pop)
        begin
            rx_count_next = rx_count_reg - 1'b1;
            // an emptied ring restarts at entry zero; otherwise the head wraps after the last entry
            if (rx_count_reg == LVL_W'(1) || rx_head_reg == LAST_PTR)
                rx_head_next = '0;
            else
                rx_head_next = rx_head_reg + 1'b1;
        end
    end

    always_comb
    begin
        tx_head_next  = tx_head_reg;
        tx_count_next = tx_count_reg;
        sending_next  = sending_reg;
        if (cm.send_start)
            sending_next = 1'b1;
        if (cm.tx_stop)
        begin
            tx_head_next  = '0;
            tx_count_next = '0;
            sending_next  = 1'b0;
        end
        else if (cm.tx_push)
            tx_count_next = tx_count_reg + 1'b1;
        else if (cm.tx_pop)
        begin
            tx_count_next = tx_count_reg - 1'b1;
            tx_head_next  = (tx_head_reg == LAST_PTR) ? '0 : tx_head_reg + 1'b1;
        end
    end

    always_comb
    begin
        wait_next = wait_reg;
        if (cm.wait_inc)
            wait_next = wait_reg + 1'b1;
        else if (cm.wait_dec)
            wait_next = wait_reg - 1'b1;
    end

    always_comb
    begin
        case (res_sel_reg)
            SEL_ZERO:  res_byte = 8'h00;
            SEL_RXMAP: res_byte = rx_byte;
            SEL_CR:    res_byte = CH_CR;
            SEL_DATA:  res_byte = data_reg;
            SEL_RXMEM: res_byte = rx_q_reg;
            SEL_TXMEM: res_byte = tx_q_reg;
            default:   res_byte = 8'h00;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cm.rx_push)
            rx_mem[rx_wr_addr] <= rx_byte;
        if (cm.rx_pop)
            rx_q_reg <= rx_mem[rx_head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cm.tx_push)
            tx_mem[tx_wr_addr] <= tx_byte;
        if (cm.tx_pop)
            tx_q_reg <= tx_mem[tx_head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cm.capture)
        begin
            data_reg <= data;
        end
        if (cm.res_set)
        begin
            res_kind_reg <= cm.res_kind;
            res_sel_reg  <= cm.res_sel;
        end
        if (cm.out_load)
        begin
            kind_reg     <= res_kind_reg;
            byte_reg     <= res_byte;
            rx_level_reg <= rx_count_reg;
            tx_level_reg <= tx_count_reg;
            busy_reg     <= sending_reg;
            readers_reg  <= wait_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg           <= CMD_RX_BYTE;
            rx_head_reg       <= '0;
            rx_count_reg      <= '0;
            tx_head_reg       <= '0;
            tx_count_reg      <= '0;
            sending_reg       <= 1'b0;
            wait_reg          <= '0;
            rx_cr_to_lf_reg   <= 1'b1;
            tx_lf_to_crlf_reg <= 1'b1;
        end
        else
        begin
            if (cm.capture)
                cmd_reg <= cmd;
            rx_head_reg  <= rx_head_next;
            rx_count_reg <= rx_count_next;
            tx_head_reg  <= tx_head_next;
            tx_count_reg <= tx_count_next;
            sending_reg  <= sending_next;
            wait_reg     <= wait_next;
            if (cfg_valid)
            begin
                if (cfg_index == CFG_RX_CR_TO_LF)
                    rx_cr_to_lf_reg <= cfg_data;
                else
                    tx_lf_to_crlf_reg <= cfg_data;
            end
        end
    end

    assign kind            = kind_reg;
    assign byte_out        = byte_reg;
    assign rx_level        = rx_level_reg;
    assign tx_level        = tx_level_reg;
    assign busy_sending    = busy_reg;
    assign readers_blocked = readers_reg;

endmodule
`default_nettype wire
